### hw/rtl/owbm_pkg.sv
`timescale 1ns / 1ps

package owbm_pkg;

    // command codes carried by a request
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // one classified request on its way from front to back
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
        logic       line;
    } t_req;

    localparam logic [15:0] HALF_US_RESET = 16'd50;

    // waveform points, in half-microsecond units
    localparam logic [6:0] RST_LOW_UNITS  = 7'd100;
    localparam logic [6:0] PRESENCE_UNITS = 7'd14;
    localparam logic [6:0] RST_REC_UNITS  = 7'd100;
    localparam logic [6:0] WR_DATA_UNITS  = 7'd2;
    localparam logic [6:0] WR_HIGH_UNITS  = 7'd22;
    localparam logic [6:0] WR_SLOT_UNITS  = 7'd34;
    localparam logic [6:0] RD_REL_UNITS   = 7'd2;
    localparam logic [6:0] RD_SAMP_UNITS  = 7'd3;
    localparam logic [6:0] RD_HIGH_UNITS  = 7'd13;
    localparam logic [6:0] RD_SLOT_UNITS  = 7'd25;

    localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

### hw/rtl/owbm_front.sv
`timescale 1ns / 1ps

module owbm_front
    import owbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    input  logic       i_line_in,
    output logic       o_req_valid,
    output t_req       o_req,
    input  logic       i_req_pop
);

    t_req       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    t_req       req_in;

    always_comb begin
        req_in.data = i_data_byte;
        req_in.line = i_line_in;
        case (i_action)
            CMD_RESET: req_in.cmd = CMD_RESET;
            CMD_WRITE: req_in.cmd = CMD_WRITE;
            CMD_READ:  req_in.cmd = CMD_READ;
            default:   req_in.cmd = CMD_TICK;
        endcase
    end

    assign o_ready     = (r_count != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_req_valid = (r_count != 2'd0);
    assign o_req       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_req_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, i_req_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= req_in;
        end
    end

endmodule

### hw/rtl/owbm_back.sv
`timescale 1ns / 1ps

module owbm_back
    import owbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_half_us_ticks,
    input  logic        i_req_valid,
    input  t_req        i_req,
    output logic        o_req_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_pin_output_enable,
    output logic        o_pin_level,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_data,
    output logic        o_presence,
    output logic        o_rejected
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_REC,
        PH_WRITE,
        PH_READ
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [15:0] r_prescale,  n_prescale;
    logic [6:0]  r_unit,      n_unit;
    logic [2:0]  r_bit_pos,   n_bit_pos;
    logic [7:0]  r_shift,     n_shift;
    logic [7:0]  r_read_byte, n_read_byte;
    logic        r_presence,  n_presence;
    logic        r_drive_en,  n_drive_en;
    logic        r_drive_lvl, n_drive_lvl;
    logic        n_done;
    logic        n_rejected;

    logic        r_out_valid;
    logic        r_o_busy;
    logic        r_o_done;
    logic        r_o_rejected;

    logic        step;

    assign step      = i_req_valid && (!r_out_valid || i_ready);
    assign o_req_pop = step;

    always_comb begin
        logic [6:0] unit_inc;
        unit_inc    = r_unit + 7'd1;
        n_phase     = r_phase;
        n_prescale  = r_prescale;
        n_unit      = r_unit;
        n_bit_pos   = r_bit_pos;
        n_shift     = r_shift;
        n_read_byte = r_read_byte;
        n_presence  = r_presence;
        n_drive_en  = r_drive_en;
        n_drive_lvl = r_drive_lvl;
        n_done      = 1'b0;
        n_rejected  = 1'b0;
        if (r_phase != PH_IDLE) begin
            n_rejected = (i_req.cmd != CMD_TICK);
            if (({1'b0, r_prescale} + 17'd1) >= {1'b0, i_half_us_ticks}) begin
                n_prescale = 16'd0;
                n_unit     = unit_inc;
                case (r_phase)
                    PH_RST_LOW: begin
                        if (unit_inc == RST_LOW_UNITS) begin
                            n_drive_lvl = 1'b1;
                            n_drive_en  = 1'b0;
                            n_phase     = PH_RST_WAIT;
                            n_unit      = 7'd0;
                        end
                    end
                    PH_RST_WAIT: begin
                        if (unit_inc == PRESENCE_UNITS) begin
                            n_presence = i_req.line;
                            n_phase    = PH_RST_REC;
                            n_unit     = 7'd0;
                        end
                    end
                    PH_RST_REC: begin
                        if (unit_inc == RST_REC_UNITS) begin
                            n_phase = PH_IDLE;
                            n_unit  = 7'd0;
                            n_done  = 1'b1;
                        end
                    end
                    PH_WRITE: begin
                        if (unit_inc == WR_DATA_UNITS) begin
                            if (r_shift[r_bit_pos]) begin
                                n_drive_lvl = 1'b1;
                            end
                        end else if (unit_inc == WR_HIGH_UNITS) begin
                            n_drive_lvl = 1'b1;
                        end else if (unit_inc == WR_SLOT_UNITS) begin
                            if (r_bit_pos == LAST_BIT) begin
                                n_phase   = PH_IDLE;
                                n_unit    = 7'd0;
                                n_bit_pos = 3'd0;
                                n_done    = 1'b1;
                            end else begin
                                n_bit_pos   = r_bit_pos + 3'd1;
                                n_unit      = 7'd0;
                                n_drive_en  = 1'b1;
                                n_drive_lvl = 1'b0;
                            end
                        end
                    end
                    PH_READ: begin
                        if (unit_inc == RD_REL_UNITS) begin
                            n_drive_en = 1'b0;
                        end else if (unit_inc == RD_SAMP_UNITS) begin
                            if (i_req.line) begin
                                n_shift[r_bit_pos] = 1'b1;
                            end
                        end else if (unit_inc == RD_HIGH_UNITS) begin
                            n_drive_lvl = 1'b1;
                            n_drive_en  = 1'b1;
                        end else if (unit_inc == RD_SLOT_UNITS) begin
                            if (r_bit_pos == LAST_BIT) begin
                                n_read_byte = r_shift;
                                n_phase     = PH_IDLE;
                                n_unit      = 7'd0;
                                n_bit_pos   = 3'd0;
                                n_done      = 1'b1;
                            end else begin
                                n_bit_pos   = r_bit_pos + 3'd1;
                                n_unit      = 7'd0;
                                n_drive_en  = 1'b1;
                                n_drive_lvl = 1'b0;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end else begin
                n_prescale = r_prescale + 16'd1;
            end
        end else if (i_req.cmd != CMD_TICK) begin
            n_bit_pos   = 3'd0;
            n_unit      = 7'd0;
            n_prescale  = 16'd0;
            n_drive_en  = 1'b1;
            n_drive_lvl = 1'b0;
            case (i_req.cmd)
                CMD_RESET: n_phase = PH_RST_LOW;
                CMD_WRITE: begin
                    n_shift = i_req.data;
                    n_phase = PH_WRITE;
                end
                default: begin
                    n_shift = 8'd0;
                    n_phase = PH_READ;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_prescale   <= 16'd0;
            r_unit       <= 7'd0;
            r_bit_pos    <= 3'd0;
            r_shift      <= 8'd0;
            r_read_byte  <= 8'd0;
            r_presence   <= 1'b1;
            r_drive_en   <= 1'b1;
            r_drive_lvl  <= 1'b1;
            r_out_valid  <= 1'b0;
            r_o_busy     <= 1'b0;
            r_o_done     <= 1'b0;
            r_o_rejected <= 1'b0;
        end else begin
            if (step) begin
                r_phase      <= n_phase;
                r_prescale   <= n_prescale;
                r_unit       <= n_unit;
                r_bit_pos    <= n_bit_pos;
                r_shift      <= n_shift;
                r_read_byte  <= n_read_byte;
                r_presence   <= n_presence;
                r_drive_en   <= n_drive_en;
                r_drive_lvl  <= n_drive_lvl;
                r_o_busy     <= (n_phase != PH_IDLE);
                r_o_done     <= n_done;
                r_o_rejected <= n_rejected;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_pin_output_enable = r_drive_en;
    assign o_pin_level         = r_drive_lvl;
    assign o_busy_res          = r_o_busy;
    assign o_done_res          = r_o_done;
    assign o_read_data         = r_read_byte;
    assign o_presence          = r_presence;
    assign o_rejected          = r_o_rejected;

`ifndef SYNTHESIS
    // a completed sequence always lands back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_done) |-> (!r_o_busy && (r_phase == PH_IDLE)))
        else $error("done reported while still busy");

    // bus released while waiting for the presence pulse
    a_presence_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RST_WAIT) |-> !r_drive_en)
        else $error("pin driven during presence wait");

    // bit index only advances inside a byte transfer
    a_bit_pos_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_pos != 3'd0) |-> ((r_phase == PH_WRITE) || (r_phase == PH_READ)))
        else $error("bit position outside a byte transfer");

    // a rejected request is only reported while a sequence was running
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && n_rejected) |-> (r_phase != PH_IDLE))
        else $error("request rejected while idle");
`endif

endmodule

### hw/rtl/onewire_bus_master.sv
`timescale 1ns / 1ps

// 1-Wire bus master timing sequencer. Every request is one clock tick of the
// sequencer and carries an action (tick only, reset pulse, write byte, read
// byte), the byte to write and the sampled bus level; every request returns
// exactly one response with pin direction, pin level, busy, done, the last
// byte read, the presence bit and a rejected flag for actions that arrive
// while a sequence runs. Timing is counted in half-microsecond units, each
// unit being half_us_ticks requests long (zero acts as one). Throughput is
// one request per clock cycle while the queue has room and responses are
// taken; a request passes the request queue, then the sequencer step that
// loads the response register. The half_us_ticks register is written through
// its own channel and must only be changed while no requests are outstanding.
module onewire_bus_master
    import owbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  logic        i_line_in,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_half_us_ticks,
    // response channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_pin_output_enable,
    output logic        o_pin_level,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_data,
    output logic        o_presence,
    output logic        o_rejected
);

    // requests (sequencer ticks) per timing unit
    logic [15:0] r_half_us_ticks;

    // classified requests between front and back
    t_req req;
    logic req_valid;
    logic req_pop;

    // configuration is always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_us_ticks <= HALF_US_RESET;
        end else if (i_cfg_valid) begin
            r_half_us_ticks <= i_cfg_half_us_ticks;
        end
    end

    // front: takes requests, decodes the action, holds them in a short queue
    owbm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .i_line_in   (i_line_in),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_pop   (req_pop)
    );

    // back: runs the waveform sequencer one request per step, registers the response
    owbm_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_half_us_ticks     (r_half_us_ticks),
        .i_req_valid         (req_valid),
        .i_req               (req),
        .o_req_pop           (req_pop),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_pin_output_enable (o_pin_output_enable),
        .o_pin_level         (o_pin_level),
        .o_busy_res          (o_busy_res),
        .o_done_res          (o_done_res),
        .o_read_data         (o_read_data),
        .o_presence          (o_presence),
        .o_rejected          (o_rejected)
    );

endmodule
